@@ hw/rtl/aes_ke_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_ke_pkg: AES-128 key expansion shared types and tables
// Word types for the key and round key channels, S-box and round constants.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_ke_pkg;

	localparam int unsigned RoundIdxW = 4;

	// index of the final round key
	localparam logic [RoundIdxW-1:0] LAST_ROUND = 4'd10;

	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
	} key_word_t;

	typedef struct packed {
		logic [63:0]          round_key_high;
		logic [63:0]          round_key_low;
		logic [RoundIdxW-1:0] round_index;
		logic                 last_key;
	} round_word_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
		8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
		8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
		8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
		8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
		8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
		8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
		8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
		8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
		8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
		8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
		8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
		8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
		8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
		8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
		8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
		8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// round constant for the round key that follows round key idx
	function automatic logic [7:0] next_rcon(input logic [RoundIdxW-1:0] idx);
		logic [7:0] rc;
		unique case (idx)
			4'd0:    rc = 8'h01;
			4'd1:    rc = 8'h02;
			4'd2:    rc = 8'h04;
			4'd3:    rc = 8'h08;
			4'd4:    rc = 8'h10;
			4'd5:    rc = 8'h20;
			4'd6:    rc = 8'h40;
			4'd7:    rc = 8'h80;
			4'd8:    rc = 8'h1b;
			4'd9:    rc = 8'h36;
			default: rc = 8'h00;
		endcase
		return rc;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/aes_ke_key_fifo.sv @@
// ----------------------------------------------------------------------------
// aes_ke_key_fifo: cipher key queue
// Small register queue between key intake and the round engine.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_ke_key_fifo
	import aes_ke_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output      logic      push_ready,
	input  wire key_word_t push_word,
	output      logic      pop_valid,
	input  wire logic      pop_ready,
	output      key_word_t pop_word
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	key_word_t       mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push_fire;
	logic            pop_fire;

	assign push_ready = (count_q != CntFull);
	assign pop_valid  = (count_q != '0);
	assign pop_word   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/aes_ke_round_engine.sv @@
// ----------------------------------------------------------------------------
// aes_ke_round_engine: round key generator
// Holds the current round key and steps to the next one per output word.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_ke_round_engine
	import aes_ke_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        key_avail,
	output      logic        key_take,
	input  wire key_word_t   key_word,
	output      logic        rk_valid,
	input  wire logic        rk_ready,
	output      round_word_t rk_word
);

	logic                 busy_q;
	logic [RoundIdxW-1:0] idx_q;
	logic [31:0]          w_q [4];
	logic [31:0]          w_nxt [4];
	logic [31:0]          t;
	logic                 last;
	logic                 out_fire;

	assign last     = (idx_q == LAST_ROUND);
	assign rk_valid = busy_q;
	assign out_fire = busy_q && rk_ready;
	// next key loads when idle or as the last word of a run leaves
	assign key_take = key_avail && (!busy_q || (out_fire && last));

	// RotWord, SubWord, Rcon, then the xor chain
	always_comb begin
		t        = sub_word({w_q[3][23:0], w_q[3][31:24]}) ^ {next_rcon(idx_q), 24'h0};
		w_nxt[0] = w_q[0] ^ t;
		w_nxt[1] = w_q[1] ^ w_nxt[0];
		w_nxt[2] = w_q[2] ^ w_nxt[1];
		w_nxt[3] = w_q[3] ^ w_nxt[2];
	end

	assign rk_word = '{
		round_key_high: {w_q[0], w_q[1]},
		round_key_low:  {w_q[2], w_q[3]},
		round_index:    idx_q,
		last_key:       last
	};

	always_ff @(posedge clk) begin
		if (key_take) begin
			w_q[0] <= key_word.key_high[63:32];
			w_q[1] <= key_word.key_high[31:0];
			w_q[2] <= key_word.key_low[63:32];
			w_q[3] <= key_word.key_low[31:0];
		end else if (out_fire && !last) begin
			w_q <= w_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (key_take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/aes128_key_expansion.sv @@
// An accepted key is queued, then loaded into the engine as round key 0 on rk.
// Throughput: one round key word per cycle while rk_ready is high, set by the
//   round engine which steps one round per accepted output word.
// The queue takes keys into free slots while the engine works or is stalled.
// Reset (arst_n low) empties the queue and idles the engine at once.
// ----------------------------------------------------------------------------
// aes128_key_expansion: AES-128 key schedule
// Takes a 128-bit cipher key and emits the eleven round keys in order.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_key_expansion
	import aes_ke_pkg::*;
#(
	// key words buffered ahead of the round engine
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// cipher key channel
	input  wire logic        key_valid,
	output      logic        key_ready,
	input  wire key_word_t   key,
	// round key channel
	output      logic        rk_valid,
	input  wire logic        rk_ready,
	output      round_word_t rk
);

	// front to back handoff
	logic      q_valid;
	logic      q_take;
	key_word_t q_word;

	// Front: key queue. Accepts a new key word whenever it has a free
	// slot, independent of what the round engine is doing.
	aes_ke_key_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_key_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (key_valid),
		.push_ready (key_ready),
		.push_word  (key),
		.pop_valid  (q_valid),
		.pop_ready  (q_take),
		.pop_word   (q_word)
	);

	// Back: round engine. Its state registers drive rk directly; each
	// accepted round key advances one round, and the last one of a run
	// hands over to the next queued key in the same cycle, so keys stream
	// with no bubble.
	aes_ke_round_engine u_round_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_avail (q_valid),
		.key_take  (q_take),
		.key_word  (q_word),
		.rk_valid  (rk_valid),
		.rk_ready  (rk_ready),
		.rk_word   (rk)
	);

endmodule

`default_nettype wire

@@ tb/aes128_key_expansion_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_key_expansion_tb: AES-128 key schedule testbench
// Feeds cipher keys and checks every round key word against a schedule built
// here from a locally computed S-box, with random gaps and stalls on both
// channels.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_key_expansion_tb
	import aes_ke_pkg::*;
;

	localparam int unsigned RoundKeys    = 11;
	localparam int unsigned MaxReported  = 10;
	localparam int unsigned StallLimit   = 2000;
	localparam int unsigned DrainCycles  = 8;

	logic        clk;
	logic        arst_n;
	logic        key_valid;
	logic        key_ready;
	key_word_t   key_in;
	logic        rk_valid;
	logic        rk_ready;
	round_word_t rk_out;

	// S-box derived from GF(2^8) inversion, independent of the package table
	logic [7:0]  sbox_calc [256];
	round_word_t round_keys_due [$];
	int unsigned mismatches;
	int unsigned quiet_cycles;
	int unsigned rx_hold;
	bit          idling_on;

	aes128_key_expansion i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_valid(key_valid),
		.key_ready(key_ready),
		.key      (key_in),
		.rk_valid (rk_valid),
		.rk_ready (rk_ready),
		.rk       (rk_out)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = 8'h00;
		sh  = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= sh;
			sh = xtime(sh);
		end
		return acc;
	endfunction

	function automatic void build_sbox();
		logic [7:0] inv;
		logic [7:0] b;
		for (int a = 0; a < 256; a++) begin
			// a^254 is the multiplicative inverse, and maps 0 to 0
			inv = 8'h01;
			for (int k = 0; k < 254; k++)
				inv = gf_mul(inv, a[7:0]);
			b = inv;
			sbox_calc[a] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
				^ {b[3:0], b[7:4]} ^ 8'h63;
		end
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {sbox_calc[w[31:24]], sbox_calc[w[23:16]], sbox_calc[w[15:8]],
			sbox_calc[w[7:0]]};
	endfunction

	// expands one cipher key into its eleven round key words
	function automatic void schedule_round_keys(input key_word_t k);
		logic [31:0] w0, w1, w2, w3, t;
		logic [7:0]  rcon;
		round_word_t rw;
		w0   = k.key_high[63:32];
		w1   = k.key_high[31:0];
		w2   = k.key_low[63:32];
		w3   = k.key_low[31:0];
		rcon = 8'h01;
		for (int r = 0; r < RoundKeys; r++) begin
			if (r != 0) begin
				t    = sbox_word({w3[23:0], w3[31:24]}) ^ {rcon, 24'h0};
				rcon = xtime(rcon);
				w0   = w0 ^ t;
				w1   = w1 ^ w0;
				w2   = w2 ^ w1;
				w3   = w3 ^ w2;
			end
			rw.round_key_high = {w0, w1};
			rw.round_key_low  = {w2, w3};
			rw.round_index    = r[RoundIdxW-1:0];
			rw.last_key       = (r == RoundKeys - 1);
			round_keys_due.push_back(rw);
		end
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned gap_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!idling_on || roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic send_key(input key_word_t k);
		int unsigned gap;
		@(negedge clk);
		key_valid = 1'b1;
		key_in    = k;
		do
			@(posedge clk);
		while (!key_ready);
		schedule_round_keys(k);
		gap = gap_len();
		if (gap != 0) begin
			@(negedge clk);
			key_valid = 1'b0;
			key_in    = {$urandom, $urandom, $urandom, $urandom};
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drop the key channel before waiting, so the last key is not taken twice
	task automatic wait_drained();
		@(negedge clk);
		key_valid = 1'b0;
		while (round_keys_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// receiver side: stalls come from the same gap mix
	always @(negedge clk) begin
		if (!arst_n) begin
			rk_ready = 1'b0;
			rx_hold  = 0;
		end else if (rx_hold != 0) begin
			rk_ready = 1'b0;
			rx_hold  = rx_hold - 1;
		end else begin
			rk_ready = 1'b1;
			rx_hold  = gap_len();
		end
	end

	always @(posedge clk) begin : check_round_keys
		round_word_t want;
		if (arst_n && rk_valid && rk_ready) begin
			if (round_keys_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReported)
					$display("%0t: round key word with none expected: %h", $time, rk_out);
			end else begin
				want = round_keys_due.pop_front();
				if (rk_out.round_key_high !== want.round_key_high ||
					rk_out.round_key_low !== want.round_key_low ||
					rk_out.round_index !== want.round_index ||
					rk_out.last_key !== want.last_key) begin
					mismatches++;
					if (mismatches <= MaxReported)
						$display("%0t: round %0d exp %h_%h last %b, got idx %0d %h_%h last %b",
							$time, want.round_index, want.round_key_high,
							want.round_key_low, want.last_key, rk_out.round_index,
							rk_out.round_key_high, rk_out.round_key_low, rk_out.last_key);
				end
			end
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if (!arst_n || (key_valid && key_ready) || (rk_valid && rk_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles == StallLimit) begin
			$display("aes128_key_expansion_tb: done, errors");
			$finish;
		end
	end

	// extremes, standard vectors and single-bit keys
	task automatic test_directed_keys();
		key_word_t k;
		send_key('0);
		send_key('1);
		send_key({64'h2b7e151628aed2a6, 64'habf7158809cf4f3c});
		send_key({64'h0001020304050607, 64'h08090a0b0c0d0e0f});
		send_key({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
		send_key({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
		send_key({64'hffffffffffffffff, 64'h0000000000000000});
		send_key({64'h0000000000000000, 64'hffffffffffffffff});
		send_key({64'h8000000000000000, 64'h0000000000000000});
		send_key({64'h0000000000000000, 64'h0000000000000001});
		k.key_high = 64'h0000000000000001;
		k.key_low  = 64'h8000000000000000;
		send_key(k);
		send_key({64'h00000000ffffffff, 64'hffffffff00000000});
	endtask

	task automatic test_random_keys(input int unsigned count);
		key_word_t k;
		logic [7:0] fill;
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 8) begin
				k = {$urandom, $urandom, $urandom, $urandom};
			end else begin
				// sparse key: one repeated byte with a few random bytes over it
				fill = $urandom;
				k    = {16{fill}};
				repeat ($urandom_range(0, 3))
					k[$urandom_range(0, 15) * 8 +: 8] = $urandom;
			end
			send_key(k);
		end
	endtask

	task automatic test_back_to_back(input int unsigned count);
		idling_on = 1'b0;
		for (int unsigned n = 0; n < count; n++)
			send_key({$urandom, $urandom, $urandom, $urandom});
		wait_drained();
		idling_on = 1'b1;
	endtask

	initial begin
		arst_n     = 1'b0;
		key_valid  = 1'b0;
		key_in     = '0;
		rk_ready   = 1'b0;
		rx_hold    = 0;
		idling_on  = 1'b1;
		mismatches = 0;
		quiet_cycles = 0;
		build_sbox();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_keys();
		wait_drained();
		test_back_to_back(12);
		test_random_keys(146);
		wait_drained();

		mismatches += round_keys_due.size();
		if (mismatches == 0)
			$display("aes128_key_expansion_tb: done, clean");
		else
			$display("aes128_key_expansion_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/aes_ke_pkg.sv
hw/rtl/aes_ke_key_fifo.sv
hw/rtl/aes_ke_round_engine.sv
hw/rtl/aes128_key_expansion.sv
tb/aes128_key_expansion_tb.sv
